[rtl/core/float_calculator_alu_unit_macros.svh]
// Assertion helpers shared by the checker.
`ifndef FLOAT_CALCULATOR_ALU_UNIT_MACROS_SVH
`define FLOAT_CALCULATOR_ALU_UNIT_MACROS_SVH

// Same-cycle implication, silent during reset.
`define FCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, silent during reset.
`define FCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fca_pkg.sv]
package fca_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_FACT = 3'd4;
	localparam logic [2:0] OP_POW  = 3'd5;

	localparam logic [1:0] FOP_ADD = 2'd0;
	localparam logic [1:0] FOP_SUB = 2'd1;
	localparam logic [1:0] FOP_MUL = 2'd2;
	localparam logic [1:0] FOP_DIV = 2'd3;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] ONE_F     = 32'h3F80_0000;

	localparam int MAX_STEPS_DEF = 1023;

	typedef struct packed {
		logic        start;
		logic [1:0]  fop;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} fpu_rsp_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

endpackage

[rtl/core/fca_in_if.sv]
interface fca_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

[rtl/core/fca_out_if.sv]
interface fca_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;
	logic        steps_clamped;

	modport source (output valid, output result_bits, output steps_clamped, input ready);
	modport sink (input valid, input result_bits, input steps_clamped, output ready);
endinterface

[rtl/core/fca_fpu.sv]
module fca_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  fca_pkg::fpu_req_t req,
	output fca_pkg::fpu_rsp_t rsp
);

	localparam int MW = 50;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_ALIGN = 3'd1;
	localparam logic [2:0] F_ADD   = 3'd2;
	localparam logic [2:0] F_MUL   = 3'd3;
	localparam logic [2:0] F_PRE   = 3'd4;
	localparam logic [2:0] F_DIV   = 3'd5;
	localparam logic [2:0] F_NORM  = 3'd6;
	localparam logic [2:0] F_ROUND = 3'd7;

	logic [2:0]        st_q;
	logic              sign_q, sb_q;
	logic signed [11:0] ea_q, eb_q, exp_q;
	logic [23:0]       ma_q, mb_q;
	logic [MW-1:0]     man_q;
	logic              sticky_q;
	logic [24:0]       rem_q;
	logic [5:0]        cnt_q;
	logic [31:0]       res_q;
	logic              done_q;

	function automatic logic [32:0] fpu_special(input logic [1:0] fop, input logic [31:0] a,
		input logic [31:0] b);
		logic na, nb, ia, ib, za, zb, sx;
		logic [32:0] r;
		na = fca_pkg::is_nan(a);
		nb = fca_pkg::is_nan(b);
		ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		za = (a[30:0] == 31'd0);
		zb = (b[30:0] == 31'd0);
		sx = a[31] ^ b[31];
		r = 33'd0;
		case (fop)
			fca_pkg::FOP_MUL: begin
				if (na || nb || (ia && zb) || (za && ib))
					r = {1'b1, fca_pkg::CANON_NAN};
				else if (ia || ib)
					r = {1'b1, sx, 8'hFF, 23'd0};
				else if (za || zb)
					r = {1'b1, sx, 31'd0};
			end
			fca_pkg::FOP_DIV: begin
				if (na || nb || (ia && ib) || (za && zb))
					r = {1'b1, fca_pkg::CANON_NAN};
				else if (ia || zb)
					r = {1'b1, sx, 8'hFF, 23'd0};
				else if (ib || za)
					r = {1'b1, sx, 31'd0};
			end
			default: begin
				if (na || nb || (ia && ib && (a[31] != b[31])))
					r = {1'b1, fca_pkg::CANON_NAN};
				else if (ia)
					r = {1'b1, a};
				else if (ib)
					r = {1'b1, b};
			end
		endcase
		return r;
	endfunction

	// operand decode at start
	logic [31:0]        b_eff;
	logic [32:0]        spec;
	logic               a_big;
	logic signed [11:0] ea_u, eb_u;
	logic [23:0]        ma_u, mb_u;

	assign b_eff = (req.fop == fca_pkg::FOP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
	assign spec  = fpu_special(req.fop, req.a, b_eff);
	assign a_big = (req.a[30:0] >= b_eff[30:0]);
	assign ea_u  = (req.a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, req.a[30:23]});
	assign eb_u  = (b_eff[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b_eff[30:23]});
	assign ma_u  = {req.a[30:23] != 8'd0, req.a[22:0]};
	assign mb_u  = {b_eff[30:23] != 8'd0, b_eff[22:0]};

	// alignment and add
	logic signed [11:0] dexp;
	logic [7:0]         dsh;
	logic [MW-1:0]      sm_full, sm_sh, big_full, sum;
	logic               lost;

	assign dexp     = ea_q - eb_q;
	assign dsh      = dexp[7:0];
	assign sm_full  = {1'b0, mb_q, 25'd0};
	assign sm_sh    = sm_full >> dsh;
	assign lost     = |(sm_full & ~({MW{1'b1}} << dsh));
	assign big_full = {1'b0, ma_q, 25'd0};
	assign sum      = (sign_q == sb_q) ? (big_full + man_q) : (big_full - man_q);

	logic [47:0] prod;
	assign prod = ma_q * mb_q;

	// restoring divide step
	logic        ge;
	logic [24:0] diff;
	assign ge   = (rem_q >= {1'b0, mb_q});
	assign diff = ge ? (rem_q - {1'b0, mb_q}) : rem_q;

	// round to nearest even
	logic [23:0]        m24, mant;
	logic               grd, stk, inc;
	logic [24:0]        r25;
	logic signed [11:0] efin, efield;
	logic [31:0]        rnd_val;

	assign m24    = man_q[49:26];
	assign grd    = man_q[25];
	assign stk    = (|man_q[24:0]) | sticky_q;
	assign inc    = grd & (stk | m24[0]);
	assign r25    = {1'b0, m24} + {24'd0, inc};
	assign mant   = r25[24] ? r25[24:1] : r25[23:0];
	assign efin   = r25[24] ? (exp_q + 12'sd1) : exp_q;
	assign efield = mant[23] ? efin : 12'sd0;
	assign rnd_val = (efield >= 12'sd255) ? {sign_q, 8'hFF, 23'd0}
		: {sign_q, efield[7:0], mant[22:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= F_IDLE;
			done_q   <= 1'b0;
			sign_q   <= 1'b0;
			sb_q     <= 1'b0;
			ea_q     <= '0;
			eb_q     <= '0;
			exp_q    <= '0;
			ma_q     <= '0;
			mb_q     <= '0;
			man_q    <= '0;
			sticky_q <= 1'b0;
			rem_q    <= '0;
			cnt_q    <= '0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				F_IDLE: begin
					if (req.start) begin
						sticky_q <= 1'b0;
						if (spec[32]) begin
							res_q  <= spec[31:0];
							done_q <= 1'b1;
						end else if (req.fop == fca_pkg::FOP_ADD ||
							req.fop == fca_pkg::FOP_SUB) begin
							// larger magnitude goes first
							if (a_big) begin
								sign_q <= req.a[31];
								sb_q   <= b_eff[31];
								ea_q   <= ea_u;
								eb_q   <= eb_u;
								ma_q   <= ma_u;
								mb_q   <= mb_u;
							end else begin
								sign_q <= b_eff[31];
								sb_q   <= req.a[31];
								ea_q   <= eb_u;
								eb_q   <= ea_u;
								ma_q   <= mb_u;
								mb_q   <= ma_u;
							end
							st_q <= F_ALIGN;
						end else begin
							sign_q <= req.a[31] ^ b_eff[31];
							ea_q   <= ea_u;
							eb_q   <= eb_u;
							ma_q   <= ma_u;
							mb_q   <= mb_u;
							st_q   <= (req.fop == fca_pkg::FOP_MUL) ? F_MUL : F_PRE;
						end
					end
				end
				F_ALIGN: begin
					man_q <= {sm_sh[MW-1:1], sm_sh[0] | lost};
					exp_q <= ea_q + 12'sd1;
					st_q  <= F_ADD;
				end
				F_ADD: begin
					man_q <= sum;
					// exact cancellation gives +0 unless both were negative
					if (sum == '0)
						sign_q <= sign_q & sb_q;
					st_q <= F_NORM;
				end
				F_MUL: begin
					man_q <= {prod, 2'b00};
					exp_q <= ea_q + eb_q - 12'sd126;
					st_q  <= F_NORM;
				end
				F_PRE: begin
					if (!ma_q[23]) begin
						ma_q <= {ma_q[22:0], 1'b0};
						ea_q <= ea_q - 12'sd1;
					end
					if (!mb_q[23]) begin
						mb_q <= {mb_q[22:0], 1'b0};
						eb_q <= eb_q - 12'sd1;
					end
					if (ma_q[23] && mb_q[23]) begin
						rem_q <= {1'b0, ma_q};
						cnt_q <= '0;
						exp_q <= ea_q - eb_q + 12'sd127;
						st_q  <= F_DIV;
					end
				end
				F_DIV: begin
					man_q <= {man_q[MW-2:0], ge};
					rem_q <= {diff[23:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MW - 1)) begin
						sticky_q <= (diff != 25'd0);
						st_q     <= F_NORM;
					end
				end
				F_NORM: begin
					if (man_q == '0) begin
						st_q <= F_ROUND;
					end else if (exp_q < -12'sd60) begin
						// far below the smallest subnormal: collapse to sticky
						sticky_q <= 1'b1;
						man_q    <= '0;
						exp_q    <= 12'sd1;
						st_q     <= F_ROUND;
					end else if (exp_q < 12'sd1) begin
						sticky_q <= sticky_q | man_q[0];
						man_q    <= {1'b0, man_q[MW-1:1]};
						exp_q    <= exp_q + 12'sd1;
					end else if (!man_q[MW-1] && exp_q > 12'sd1) begin
						man_q <= {man_q[MW-2:0], 1'b0};
						exp_q <= exp_q - 12'sd1;
					end else begin
						st_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					res_q  <= rnd_val;
					done_q <= 1'b1;
					st_q   <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

[rtl/core/float_calculator_alu_unit.sv]
// Channel   Dir  Beat contents
// in_ch     in   operation, operand_a, operand_b
// out_ch    out  result_bits, steps_clamped
//
// One beat in, one beat out; a new beat is taken only after the result is gone.
// All arithmetic operations, including those with NaN, infinity and zero operands, run on
// the one shared rounding FP unit. Factorial and power issue one multiply and one add of
// 1.0 per step on that unit, for up to MAX_STEPS steps.
// arst_n clears the sequencer and the output register; a stalled result holds.
module float_calculator_alu_unit #(
	parameter int MAX_STEPS = fca_pkg::MAX_STEPS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	fca_in_if.sink   in_ch,
	fca_out_if.source out_ch
);

	localparam int SW = $clog2(MAX_STEPS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_ARITH = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_INC   = 3'd5;

	logic [2:0]        st_q;
	logic [2:0]        op_q;
	logic [31:0]       a_q, b_q, acc_q, fi_q, res_q;
	logic [SW-1:0]     steps_q;
	logic              clamp_q, ovalid_q;
	fca_pkg::fpu_req_t req_q;
	fca_pkg::fpu_rsp_t rsp;

	fca_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	// loop tests; the counter value is always a positive float
	logic fact_go, pow_go, go;
	assign fact_go = !a_q[31] && !fca_pkg::is_nan(a_q) && (fi_q <= a_q);
	assign pow_go  = !b_q[31] && !fca_pkg::is_nan(b_q) && (fi_q < b_q);
	assign go      = (op_q == fca_pkg::OP_FACT) ? fact_go : pow_go;

	assign in_ch.ready          = (st_q == S_IDLE) && !ovalid_q;
	assign out_ch.valid         = ovalid_q;
	assign out_ch.result_bits   = res_q;
	assign out_ch.steps_clamped = clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			op_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
			fi_q     <= '0;
			res_q    <= '0;
			steps_q  <= '0;
			clamp_q  <= 1'b0;
			ovalid_q <= 1'b0;
			req_q    <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (ovalid_q && out_ch.ready)
				ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.operation;
						a_q  <= in_ch.operand_a;
						b_q  <= in_ch.operand_b;
						st_q <= S_START;
					end
				end
				S_START: begin
					steps_q <= '0;
					fi_q    <= fca_pkg::ONE_F;
					case (op_q)
						fca_pkg::OP_ADD, fca_pkg::OP_SUB, fca_pkg::OP_MUL,
						fca_pkg::OP_DIV: begin
							req_q <= {1'b1, op_q[1:0], a_q, b_q};
							st_q  <= S_ARITH;
						end
						fca_pkg::OP_FACT: begin
							acc_q <= fca_pkg::ONE_F;
							st_q  <= S_CHECK;
						end
						fca_pkg::OP_POW: begin
							if (b_q[30:0] == 31'd0) begin
								res_q    <= fca_pkg::ONE_F;
								clamp_q  <= 1'b0;
								ovalid_q <= 1'b1;
								st_q     <= S_IDLE;
							end else begin
								acc_q <= a_q;
								st_q  <= S_CHECK;
							end
						end
						default: begin
							res_q    <= '0;
							clamp_q  <= 1'b0;
							ovalid_q <= 1'b1;
							st_q     <= S_IDLE;
						end
					endcase
				end
				S_ARITH: begin
					if (rsp.done) begin
						res_q    <= rsp.value;
						clamp_q  <= 1'b0;
						ovalid_q <= 1'b1;
						st_q     <= S_IDLE;
					end
				end
				S_CHECK: begin
					if (!go || steps_q == SW'(MAX_STEPS)) begin
						// canonicalize a NaN passed through unchanged
						res_q    <= fca_pkg::is_nan(acc_q) ? fca_pkg::CANON_NAN : acc_q;
						clamp_q  <= go;
						ovalid_q <= 1'b1;
						st_q     <= S_IDLE;
					end else begin
						req_q <= {1'b1, fca_pkg::FOP_MUL, acc_q,
							(op_q == fca_pkg::OP_FACT) ? fi_q : a_q};
						st_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (rsp.done) begin
						acc_q   <= rsp.value;
						steps_q <= steps_q + SW'(1);
						req_q   <= {1'b1, fca_pkg::FOP_ADD, fi_q, fca_pkg::ONE_F};
						st_q    <= S_INC;
					end
				end
				S_INC: begin
					if (rsp.done) begin
						fi_q <= rsp.value;
						st_q <= S_CHECK;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/fca_chk.sv]
`include "float_calculator_alu_unit_macros.svh"

module fca_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_bits,
	input logic        steps_clamped
);

	`FCA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_bits) && $stable(steps_clamped), "stalled result beat changed")
	`FCA_ASSERT_NOW(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input taken while a result waits")
	`FCA_ASSERT_NEXT(a_not_instant, clk, arst_n, in_valid && in_ready, !out_valid, "result appeared right after the input beat")
	`FCA_ASSERT_NOW(a_canon_nan, clk, arst_n, out_valid && result_bits[30:23] == 8'hFF && result_bits[22:0] != 23'd0, result_bits == 32'h7FC0_0000, "NaN result not canonical")

endmodule

bind float_calculator_alu_unit fca_chk u_fca_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.result_bits   (out_ch.result_bits),
	.steps_clamped (out_ch.steps_clamped)
);

[dv/fca_result_checker.sv]
module fca_result_checker (
	input  logic clk,
	input  logic arst_n,
	fca_in_if    in_ch,
	fca_out_if   out_ch,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [31:0] POS_INF = 32'h7F80_0000;

	typedef struct {
		logic [31:0] bits;
		logic        clamped;
	} alu_result_t;

	alu_result_t expected_results[$];

	function automatic logic single_is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	// Exact conversion of a single pattern to a double value.
	function automatic real widen_to_double(input logic [31:0] f);
		logic        s;
		int          ex;
		logic [23:0] man;
		s = f[31];
		if (f[30:23] == 8'hFF) begin
			if (f[22:0] != 23'd0)
				return $bitstoreal(64'h7FF8_0000_0000_0000);
			return $bitstoreal({s, 11'h7FF, 52'd0});
		end
		if (f[30:0] == 31'd0)
			return $bitstoreal({s, 63'd0});
		if (f[30:23] == 8'd0) begin
			ex = -126;
			man = {1'b0, f[22:0]};
			for (int k = 0; k < 24 && !man[23]; k++) begin
				man = man << 1;
				ex--;
			end
		end else begin
			ex = int'(f[30:23]) - 127;
			man = {1'b1, f[22:0]};
		end
		return $bitstoreal({s, 11'(ex + 1023), man[22:0], 29'd0});
	endfunction

	// Round a double to single, nearest-even, subnormals included.
	// A double holds every float op result closely enough that this second rounding is exact.
	function automatic logic [31:0] narrow_to_single(input real v);
		logic [63:0] d;
		logic        s;
		int          ex;
		int          sh;
		logic [63:0] sig;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		d = $realtobits(v);
		s = d[63];
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 52'd0) ? fca_pkg::CANON_NAN : {s, POS_INF[30:0]};
		if (d[62:52] == 11'd0)
			return {s, 31'd0};
		ex = int'(d[62:52]) - 1023;
		sig = {11'd0, 1'b1, d[51:0]};
		sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (sh > 60)
			sh = 60;
		q = sig >> sh;
		rem = sig & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		if (ex >= -126) begin
			if (q[24]) begin
				q = q >> 1;
				ex++;
			end
			if (ex > 127)
				return {s, POS_INF[30:0]};
			return {s, 8'(ex + 127), q[22:0]};
		end
		// a carry into bit 23 lands on the smallest normal by itself
		return {s, q[30:0]};
	endfunction

	function automatic alu_result_t predict_result(input logic [2:0] op,
		input logic [31:0] a, input logic [31:0] b);
		alu_result_t r;
		real         ra;
		real         rb;
		logic [31:0] acc;
		int          steps;
		ra = widen_to_double(a);
		rb = widen_to_double(b);
		r.clamped = 1'b0;
		r.bits = 32'd0;
		steps = 0;
		case (op)
			fca_pkg::OP_ADD: r.bits = narrow_to_single(ra + rb);
			fca_pkg::OP_SUB: r.bits = narrow_to_single(ra - rb);
			fca_pkg::OP_MUL: r.bits = narrow_to_single(ra * rb);
			fca_pkg::OP_DIV: r.bits = narrow_to_single(ra / rb);
			fca_pkg::OP_FACT: begin
				acc = fca_pkg::ONE_F;
				if (!single_is_nan(a)) begin
					for (int i = 1; real'(i) <= ra; i++) begin
						if (steps == fca_pkg::MAX_STEPS_DEF) begin
							r.clamped = 1'b1;
							break;
						end
						acc = narrow_to_single(widen_to_double(acc) * real'(i));
						steps++;
					end
				end
				r.bits = acc;
			end
			fca_pkg::OP_POW: begin
				if (b[30:0] == 31'd0) begin
					acc = fca_pkg::ONE_F;
				end else begin
					acc = a;
					if (!single_is_nan(b)) begin
						for (int i = 1; real'(i) < rb; i++) begin
							if (steps == fca_pkg::MAX_STEPS_DEF) begin
								r.clamped = 1'b1;
								break;
							end
							acc = narrow_to_single(widen_to_double(acc) * ra);
							steps++;
						end
					end
				end
				r.bits = single_is_nan(acc) ? fca_pkg::CANON_NAN : acc;
			end
			default: r.bits = 32'd0;
		endcase
		return r;
	endfunction

	assign outstanding = expected_results.size();

	initial mismatches = 0;

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(predict_result(in_ch.operation,
					in_ch.operand_a, in_ch.operand_b));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: result_bits %h",
						out_ch.result_bits);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.result_bits !== want.bits) begin
						$error("result_bits: expected %h, got %h", want.bits,
							out_ch.result_bits);
						mismatches++;
					end
					if (out_ch.steps_clamped !== want.clamped) begin
						$error("steps_clamped: expected %b, got %b", want.clamped,
							out_ch.steps_clamped);
						mismatches++;
					end
				end
			end
		end
	end
endmodule

[dv/float_calculator_alu_unit_tb.sv]
module float_calculator_alu_unit_tb;

	localparam logic [31:0] POS_INF  = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
	localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [31:0] MAX_NORM = 32'h7F7F_FFFF;
	localparam logic [31:0] MIN_SUB  = 32'h0000_0001;
	localparam logic [31:0] TWO_F    = 32'h4000_0000;
	localparam logic [31:0] HALF_F   = 32'h3F00_0000;
	localparam logic [2:0]  OP_BAD6  = 3'd6;
	localparam logic [2:0]  OP_BAD7  = 3'd7;
	localparam int          ITEMS    = 500;

	logic clk;
	logic arst_n;
	int   cycle;
	int   mismatches;
	int   outstanding;

	fca_in_if  in_ch ();
	fca_out_if out_ch ();

	float_calculator_alu_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	fca_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) cycle <= cycle + 1;

	// no idling for a while in every window
	function automatic logic take_break();
		if ((cycle % 20000) < 5000)
			return 1'b0;
		return $urandom_range(0, 99) < 17;
	endfunction

	// Small integer or half-integer as a single pattern.
	function automatic logic [31:0] small_value(input int k, input logic frac);
		return checker_i.narrow_to_single(real'(k) + (frac ? 0.5 : 0.0));
	endfunction

	function automatic logic [31:0] any_operand();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 7))
					0: return 32'd0;
					1: return NEG_ZERO;
					2: return POS_INF;
					3: return NEG_INF;
					4: return {1'b0, 8'hFF, 23'($urandom)};
					5: return MAX_NORM;
					6: return MIN_SUB;
					default: return fca_pkg::ONE_F;
				endcase
			end
			1: return {1'($urandom), 8'd0, 23'($urandom)};
			2, 3, 4: return $urandom;
			default: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
		endcase
	endfunction

	task automatic send_beat(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
		while (take_break()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// receiver: random stalls plus one long hold-off to back the block up
	initial begin
		int holdoff;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		holdoff = 0;
		forever begin
			@(posedge clk);
			if (cycle == 3000)
				holdoff = 600;
			if (holdoff > 0) begin
				holdoff--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !take_break();
			end
		end
	end

	initial begin
		#40_000_000;
		$display("float_calculator_alu_unit regression: fail");
		$finish;
	end

	initial begin
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		int          pick;
		cycle = 0;
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= fca_pkg::OP_ADD;
		in_ch.operand_a <= 32'd0;
		in_ch.operand_b <= 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(fca_pkg::OP_ADD, fca_pkg::ONE_F, TWO_F);
		send_beat(fca_pkg::OP_ADD, POS_INF, NEG_INF);
		send_beat(fca_pkg::OP_SUB, 32'd0, 32'd0);
		send_beat(fca_pkg::OP_SUB, MIN_SUB, NEG_ZERO);
		send_beat(fca_pkg::OP_MUL, MAX_NORM, TWO_F);
		send_beat(fca_pkg::OP_MUL, MIN_SUB, HALF_F);
		send_beat(fca_pkg::OP_DIV, fca_pkg::ONE_F, 32'd0);
		send_beat(fca_pkg::OP_DIV, 32'd0, NEG_ZERO);
		send_beat(fca_pkg::OP_DIV, 32'hFFFF_FFFF, fca_pkg::ONE_F);
		send_beat(fca_pkg::OP_FACT, small_value(5, 1'b0), 32'hFFFF_FFFF);
		send_beat(fca_pkg::OP_FACT, HALF_F, 32'd0);
		send_beat(fca_pkg::OP_FACT, {1'b0, 8'hFF, 23'h1}, 32'd0);
		send_beat(fca_pkg::OP_FACT, small_value(1023, 1'b0), 32'd0);
		send_beat(fca_pkg::OP_FACT, small_value(1024, 1'b0), 32'd0);
		send_beat(fca_pkg::OP_FACT, POS_INF, 32'd0);
		send_beat(fca_pkg::OP_POW, small_value(3, 1'b0), 32'd0);
		send_beat(fca_pkg::OP_POW, small_value(3, 1'b0), NEG_ZERO);
		send_beat(fca_pkg::OP_POW, small_value(7, 1'b0), fca_pkg::ONE_F);
		send_beat(fca_pkg::OP_POW, TWO_F, {1'b0, 8'hFF, 23'h40_0001});
		send_beat(fca_pkg::OP_POW, TWO_F, small_value(2, 1'b1));
		send_beat(fca_pkg::OP_POW, {1'b1, 8'hFF, 23'h5}, HALF_F);
		send_beat(fca_pkg::OP_POW, fca_pkg::ONE_F, POS_INF);
		send_beat(OP_BAD6, fca_pkg::ONE_F, TWO_F);
		send_beat(OP_BAD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int n = 0; n < ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			a = any_operand();
			b = any_operand();
			if (pick < 70) begin
				op = 3'($urandom_range(0, 3));
			end else if (pick < 82) begin
				op = fca_pkg::OP_FACT;
				// keep step counts small; a rare raw pattern may saturate
				if ($urandom_range(0, 99) != 0)
					a = small_value($urandom_range(0, 40), 1'($urandom));
			end else if (pick < 96) begin
				op = fca_pkg::OP_POW;
				if ($urandom_range(0, 99) != 0) begin
					b = small_value($urandom_range(0, 14), 1'($urandom));
					b[31] = ($urandom_range(0, 3) == 0);
				end
			end else begin
				op = 3'($urandom_range(6, 7));
			end
			send_beat(op, a, b);
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("float_calculator_alu_unit regression: pass");
		else
			$display("float_calculator_alu_unit regression: fail");
		$finish;
	end
endmodule
